@@ design/wepid_pkg.sv @@
// ----------------------------------------------------------------------------
// wepid_pkg
// Shared types and constants of the wrapped-error PID controller: register
// indexes, fold modes, the configuration bundle and the fold constants.
// ----------------------------------------------------------------------------
package wepid_pkg;

	// width of the gain registers
	localparam int GAIN_W = 32;

	// fold constants, in whole units before the fraction shift
	localparam int FOLD_8191  = 8191;
	localparam int FOLD_4095  = 4095;
	localparam int FOLD_360   = 360;
	localparam int FOLD_65535 = 65535;
	localparam int FOLD_32767 = 32767;

	// configuration register indexes
	typedef enum logic [3:0] {
		REG_GAIN_P         = 4'd0,
		REG_GAIN_I         = 4'd1,
		REG_GAIN_D         = 4'd2,
		REG_DEAD_BAND      = 4'd3,
		REG_INTEGRAL_LIMIT = 4'd4,
		REG_IOUT_LIMIT     = 4'd5,
		REG_OUT_LIMIT      = 4'd6,
		REG_WRAP_MODE      = 4'd7
	} reg_index_t;

	// error fold modes
	typedef enum logic [2:0] {
		WRAP_NONE        = 3'd0,
		WRAP_8191        = 3'd1,
		WRAP_8191_4095   = 3'd2,
		WRAP_360         = 3'd3,
		WRAP_65535       = 3'd4,
		WRAP_65535_32767 = 3'd5
	} wrap_mode_t;

	// configuration bundle
	typedef struct packed {
		logic signed [GAIN_W-1:0] gain_p;
		logic signed [GAIN_W-1:0] gain_i;
		logic signed [GAIN_W-1:0] gain_d;
		logic [30:0]              dead_band;
		logic [30:0]              integral_limit;
		logic [30:0]              iout_limit;
		logic [30:0]              out_limit;
		logic [2:0]               wrap_mode;
	} cfg_t;

endpackage

@@ design/wrapped_error_pid_controller_unit.sv @@
// ----------------------------------------------------------------------------
// wrapped_error_pid_controller_unit
// Positional PID step with folded error, dead band, integral clamp and
// saturated I term and drive output.
// ----------------------------------------------------------------------------
//  channel  handshake               payload
//  sample   sample_valid/stall      target, measure
//  drive    drive_valid/stall       drive
//  cfg      cfg_valid/cfg_ready     cfg_index, cfg_data
//
// One beat per cycle sustained while drive_stall is low; six register stages from sample to drive.
// The rate is set by the integral loop: one add and clamp per cycle.
// Reset clears the configuration, the integral, the last error and all
// stage valids. A stalled drive beat holds; stages behind it fill their
// empty slots before sample_stall rises.
module wrapped_error_pid_controller_unit #(
	parameter int DATA_WIDTH     = 32,
	parameter int FRAC_BITS      = 8,
	parameter int GAIN_FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               sample_valid,
	output logic               sample_stall,
	input  logic signed [31:0] target,
	input  logic signed [31:0] measure,
	output logic               drive_valid,
	input  logic               drive_stall,
	output logic signed [31:0] drive,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [3:0]         cfg_index,
	input  logic [31:0]        cfg_data
);

	localparam int DW = DATA_WIDTH;
	localparam int AW = DATA_WIDTH + 1;
	localparam int CW = ((DW > 32) ? DW : 32) + 1;
	localparam int SW = ((DW + 2 > 33) ? DW + 2 : 33) + 1;

	localparam logic signed [SW-1:0] S_ONE  = SW'(1);
	localparam logic signed [SW-1:0] S_VMAX = (S_ONE <<< (DW - 1)) - S_ONE;
	localparam logic signed [SW-1:0] S_VMIN = -S_VMAX - S_ONE;
	localparam logic signed [SW-1:0] S_MAX32 = (S_ONE <<< 31) - S_ONE;
	localparam logic signed [SW-1:0] S_MIN32 = -S_MAX32 - S_ONE;

	wepid_pkg::cfg_t cfg_q;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic en1, en2, en3, en4, en5, en6;

	logic signed [31:0]   target_s1;
	logic signed [31:0]   measure_s1;
	logic signed [DW-1:0] err;
	logic signed [DW-1:0] err_s2;
	logic signed [DW-1:0] integ_next;
	logic signed [DW:0]   diff;
	logic signed [DW-1:0] e_s3;
	logic signed [DW-1:0] integ_s3;
	logic signed [DW:0]   diff_s3;
	logic signed [DW-1:0] p_res;
	logic signed [DW-1:0] i_res;
	logic signed [DW-1:0] d_res;
	logic signed [CW-1:0] i_ext;
	logic signed [CW-1:0] i_lim;
	logic signed [CW-1:0] i_clamp;
	logic signed [DW-1:0] p_s5;
	logic signed [DW-1:0] i_s5;
	logic signed [DW-1:0] d_s5;
	logic signed [SW-1:0] sum;
	logic signed [SW-1:0] o_lim;
	logic signed [SW-1:0] sum_c;
	logic signed [SW-1:0] sum_d;
	logic signed [SW-1:0] sum_32;
	logic signed [31:0]   drive_q;

	// configuration writes, always taken
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (wepid_pkg::reg_index_t'(cfg_index))
				wepid_pkg::REG_GAIN_P:         cfg_q.gain_p         <= cfg_data;
				wepid_pkg::REG_GAIN_I:         cfg_q.gain_i         <= cfg_data;
				wepid_pkg::REG_GAIN_D:         cfg_q.gain_d         <= cfg_data;
				wepid_pkg::REG_DEAD_BAND:      cfg_q.dead_band      <= cfg_data[30:0];
				wepid_pkg::REG_INTEGRAL_LIMIT: cfg_q.integral_limit <= cfg_data[30:0];
				wepid_pkg::REG_IOUT_LIMIT:     cfg_q.iout_limit     <= cfg_data[30:0];
				wepid_pkg::REG_OUT_LIMIT:      cfg_q.out_limit      <= cfg_data[30:0];
				wepid_pkg::REG_WRAP_MODE:      cfg_q.wrap_mode      <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	// stage enables: a stage moves when it is empty or the next one moves
	assign en6 = !v_s6 || !drive_stall;
	assign en5 = !v_s5 || en6;
	assign en4 = !v_s4 || en5;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign sample_stall = !en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (en1) v_s1 <= sample_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
			if (en5) v_s5 <= v_s4;
			if (en6) v_s6 <= v_s5;
		end
	end

	// input register
	always_ff @(posedge clk) begin
		if (en1) begin
			target_s1  <= target;
			measure_s1 <= measure;
		end
	end

	// error, fold and dead band
	wepid_err #(
		.DATA_WIDTH (DW),
		.FRAC_BITS  (FRAC_BITS)
	) u_err (
		.target  (target_s1),
		.measure (measure_s1),
		.cfg     (cfg_q),
		.err     (err)
	);

	always_ff @(posedge clk) begin
		if (en2)
			err_s2 <= err;
	end

	// integral and last error, updated as a beat moves on
	wepid_integ #(
		.DATA_WIDTH (DW)
	) u_integ (
		.clk            (clk),
		.arst_n         (arst_n),
		.adv            (v_s2 && en3),
		.err            (err_s2),
		.integral_limit (cfg_q.integral_limit),
		.integ_next     (integ_next),
		.diff           (diff)
	);

	always_ff @(posedge clk) begin
		if (en3) begin
			e_s3     <= err_s2;
			integ_s3 <= integ_next;
			diff_s3  <= diff;
		end
	end

	// gain multiplies
	wepid_mul #(
		.A_WIDTH        (AW),
		.DATA_WIDTH     (DW),
		.GAIN_FRAC_BITS (GAIN_FRAC_BITS)
	) u_mul_p (
		.clk  (clk),
		.en   (en4),
		.a    (AW'(e_s3)),
		.gain (cfg_q.gain_p),
		.res  (p_res)
	);

	wepid_mul #(
		.A_WIDTH        (AW),
		.DATA_WIDTH     (DW),
		.GAIN_FRAC_BITS (GAIN_FRAC_BITS)
	) u_mul_i (
		.clk  (clk),
		.en   (en4),
		.a    (AW'(integ_s3)),
		.gain (cfg_q.gain_i),
		.res  (i_res)
	);

	wepid_mul #(
		.A_WIDTH        (AW),
		.DATA_WIDTH     (DW),
		.GAIN_FRAC_BITS (GAIN_FRAC_BITS)
	) u_mul_d (
		.clk  (clk),
		.en   (en4),
		.a    (diff_s3),
		.gain (cfg_q.gain_d),
		.res  (d_res)
	);

	// I term clamp
	always_comb begin
		i_ext = CW'(i_res);
		i_lim = $signed(CW'(cfg_q.iout_limit));
		if (i_ext < -i_lim)
			i_clamp = -i_lim;
		else if (i_ext > i_lim)
			i_clamp = i_lim;
		else
			i_clamp = i_ext;
	end

	always_ff @(posedge clk) begin
		if (en5) begin
			p_s5 <= p_res;
			i_s5 <= i_clamp[DW-1:0];
			d_s5 <= d_res;
		end
	end

	// sum, output clamp, value range, then the drive field range
	always_comb begin
		sum   = SW'(p_s5) + SW'(i_s5) + SW'(d_s5);
		o_lim = $signed(SW'(cfg_q.out_limit));
		if (sum < -o_lim)
			sum_c = -o_lim;
		else if (sum > o_lim)
			sum_c = o_lim;
		else
			sum_c = sum;
		if (sum_c > S_VMAX)
			sum_d = S_VMAX;
		else if (sum_c < S_VMIN)
			sum_d = S_VMIN;
		else
			sum_d = sum_c;
		if (sum_d > S_MAX32)
			sum_32 = S_MAX32;
		else if (sum_d < S_MIN32)
			sum_32 = S_MIN32;
		else
			sum_32 = sum_d;
	end

	// drive register
	always_ff @(posedge clk) begin
		if (en6)
			drive_q <= sum_32[31:0];
	end

	assign drive       = drive_q;
	assign drive_valid = v_s6;

`ifndef SYNTHESIS
	// an empty input stage always takes a beat
	a_empty_takes: assert property (@(posedge clk) disable iff (!arst_n)
		!v_s1 |-> !sample_stall)
		else $error("input stage empty but sample stalled");

	// an accepted beat lands in the input stage
	a_accept_fills: assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid && !sample_stall |=> v_s1)
		else $error("accepted beat lost at input stage");

	// a blocked error stage holds its beat while the state does not advance
	a_err_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && !en3 |=> v_s2 && $stable(err_s2))
		else $error("blocked error stage changed");

	// a blocked term stage holds its beat
	a_term_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s5 && !en6 |=> v_s5 && $stable(p_s5) && $stable(i_s5) && $stable(d_s5))
		else $error("blocked term stage changed");
`endif

endmodule

@@ design/wepid_err.sv @@
// ----------------------------------------------------------------------------
// wepid_err
// Error path: target minus measure, saturated to the value width, folded
// into half a revolution by the selected mode, then the dead band.
// ----------------------------------------------------------------------------
module wepid_err #(
	parameter int DATA_WIDTH = 32,
	parameter int FRAC_BITS  = 8
) (
	input  logic signed [31:0]           target,
	input  logic signed [31:0]           measure,
	input  wepid_pkg::cfg_t              cfg,
	output logic signed [DATA_WIDTH-1:0] err
);

	// working width covers the value range and the largest fold constant
	localparam int FW = ((DATA_WIDTH > 34) ? DATA_WIDTH : 34) + 2;

	localparam logic signed [FW-1:0] ONE  = FW'(1);
	localparam logic signed [FW-1:0] VMAX = (ONE <<< (DATA_WIDTH - 1)) - ONE;
	localparam logic signed [FW-1:0] VMIN = -VMAX - ONE;

	localparam logic signed [FW-1:0] M_8191  = FW'(wepid_pkg::FOLD_8191) <<< FRAC_BITS;
	localparam logic signed [FW-1:0] M_4095  = FW'(wepid_pkg::FOLD_4095) <<< FRAC_BITS;
	localparam logic signed [FW-1:0] M_360   = FW'(wepid_pkg::FOLD_360) <<< FRAC_BITS;
	localparam logic signed [FW-1:0] M_65535 = FW'(wepid_pkg::FOLD_65535) <<< FRAC_BITS;
	localparam logic signed [FW-1:0] M_32767 = FW'(wepid_pkg::FOLD_32767) <<< FRAC_BITS;

	// one fold: shift by a full turn when the error exceeds half a turn
	function automatic logic signed [FW-1:0] fold_err(
		input logic signed [FW-1:0] e,
		input logic signed [FW-1:0] m
	);
		logic signed [FW-1:0] a;
		logic signed [FW-1:0] r;
		a = e[FW-1] ? -e : e;
		r = e;
		if ((a <<< 1) > m)
			r = e[FW-1] ? (e + m) : (e - m);
		return r;
	endfunction

	logic signed [FW-1:0] diff;
	logic signed [FW-1:0] sat_e;
	logic signed [FW-1:0] fold_8191_e;
	logic signed [FW-1:0] fold_65535_e;
	logic signed [FW-1:0] wrapped_e;
	logic [FW-1:0]        mag;
	logic [FW-1:0]        band;

	// raw error, saturated to the value range
	always_comb begin
		diff = FW'(target) - FW'(measure);
		if (diff > VMAX)
			sat_e = VMAX;
		else if (diff < VMIN)
			sat_e = VMIN;
		else
			sat_e = diff;
	end

	// fold select
	always_comb begin
		fold_8191_e  = fold_err(sat_e, M_8191);
		fold_65535_e = fold_err(sat_e, M_65535);
		case (wepid_pkg::wrap_mode_t'(cfg.wrap_mode))
			wepid_pkg::WRAP_8191:        wrapped_e = fold_8191_e;
			wepid_pkg::WRAP_8191_4095:   wrapped_e = fold_err(fold_8191_e, M_4095);
			wepid_pkg::WRAP_360:         wrapped_e = fold_err(sat_e, M_360);
			wepid_pkg::WRAP_65535:       wrapped_e = fold_65535_e;
			wepid_pkg::WRAP_65535_32767: wrapped_e = fold_err(fold_65535_e, M_32767);
			default:                     wrapped_e = sat_e;
		endcase
	end

	// dead band, a fold never grows the magnitude so the value width holds
	always_comb begin
		mag  = wrapped_e[FW-1] ? FW'(-wrapped_e) : FW'(wrapped_e);
		band = FW'(cfg.dead_band);
		if (mag <= band)
			err = '0;
		else
			err = wrapped_e[DATA_WIDTH-1:0];
	end

endmodule

@@ design/wepid_integ.sv @@
// ----------------------------------------------------------------------------
// wepid_integ
// Controller state: the clamped error integral and the last error, with the
// next integral and the error difference for the D term.
// ----------------------------------------------------------------------------
module wepid_integ #(
	parameter int DATA_WIDTH = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         adv,
	input  logic signed [DATA_WIDTH-1:0] err,
	input  logic [30:0]                  integral_limit,
	output logic signed [DATA_WIDTH-1:0] integ_next,
	output logic signed [DATA_WIDTH:0]   diff
);

	localparam int IW = ((DATA_WIDTH + 1 > 32) ? DATA_WIDTH + 1 : 32) + 1;

	localparam logic signed [IW-1:0] ONE  = IW'(1);
	localparam logic signed [IW-1:0] VMAX = (ONE <<< (DATA_WIDTH - 1)) - ONE;
	localparam logic signed [IW-1:0] VMIN = -VMAX - ONE;

	logic signed [DATA_WIDTH-1:0] integ_q;
	logic signed [DATA_WIDTH-1:0] prev_q;
	logic signed [IW-1:0]         sum_i;
	logic signed [IW-1:0]         lim_i;
	logic signed [IW-1:0]         clamp_i;
	logic signed [IW-1:0]         sat_i;

	// integral plus error, clamped to the limit, then to the value range
	always_comb begin
		sum_i = IW'(integ_q) + IW'(err);
		lim_i = $signed(IW'(integral_limit));
		if (sum_i < -lim_i)
			clamp_i = -lim_i;
		else if (sum_i > lim_i)
			clamp_i = lim_i;
		else
			clamp_i = sum_i;
		if (clamp_i > VMAX)
			sat_i = VMAX;
		else if (clamp_i < VMIN)
			sat_i = VMIN;
		else
			sat_i = clamp_i;
		integ_next = sat_i[DATA_WIDTH-1:0];
	end

	// exact error difference
	assign diff = (DATA_WIDTH + 1)'(err) - (DATA_WIDTH + 1)'(prev_q);

	// state update once per beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integ_q <= '0;
			prev_q  <= '0;
		end else if (adv) begin
			integ_q <= integ_next;
			prev_q  <= err;
		end
	end

endmodule

@@ design/wepid_mul.sv @@
// ----------------------------------------------------------------------------
// wepid_mul
// Gain multiply: operand split in two halves, partial products registered,
// then recombined, shifted down by the gain fraction and saturated.
// ----------------------------------------------------------------------------
module wepid_mul #(
	parameter int A_WIDTH        = 33,
	parameter int DATA_WIDTH     = 32,
	parameter int GAIN_FRAC_BITS = 16
) (
	input  logic                                 clk,
	input  logic                                 en,
	input  logic signed [A_WIDTH-1:0]            a,
	input  logic signed [wepid_pkg::GAIN_W-1:0]  gain,
	output logic signed [DATA_WIDTH-1:0]         res
);

	localparam int GW   = wepid_pkg::GAIN_W;
	localparam int LO_W = A_WIDTH / 2;
	localparam int HI_W = A_WIDTH - LO_W;
	localparam int PW   = A_WIDTH + GW;

	localparam logic signed [PW-1:0] ONE  = PW'(1);
	localparam logic signed [PW-1:0] VMAX = (ONE <<< (DATA_WIDTH - 1)) - ONE;
	localparam logic signed [PW-1:0] VMIN = -VMAX - ONE;

	logic [LO_W-1:0]             lo;
	logic signed [HI_W-1:0]      hi;
	logic signed [LO_W+GW:0]     pl_s4;
	logic signed [HI_W+GW-1:0]   ph_s4;
	logic signed [PW-1:0]        full;
	logic signed [PW-1:0]        shifted;

	assign lo = a[LO_W-1:0];
	assign hi = a[A_WIDTH-1:LO_W];

	// partial products
	always_ff @(posedge clk) begin
		if (en) begin
			pl_s4 <= $signed({1'b0, lo}) * gain;
			ph_s4 <= hi * gain;
		end
	end

	// recombine, floor shift, saturate
	always_comb begin
		full    = $signed({ph_s4, {LO_W{1'b0}}}) + PW'(pl_s4);
		shifted = full >>> GAIN_FRAC_BITS;
		if (shifted > VMAX)
			res = VMAX[DATA_WIDTH-1:0];
		else if (shifted < VMIN)
			res = VMIN[DATA_WIDTH-1:0];
		else
			res = shifted[DATA_WIDTH-1:0];
	end

endmodule

@@ dv/wrapped_error_pid_controller_unit_test.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// wrapped_error_pid_controller_unit_test
// Self-checking bench for the wrapped-error PID step. Sample beats and
// register writes are driven from plain tasks; a scoreboard class predicts
// each drive beat and compares them in order. Both channels see random gaps
// and stalls, plus one long drive hold-off and mid-phase drain pauses.
// ---------------------------------------------------------------------------
module wrapped_error_pid_controller_unit_test;

	localparam int FRAC = 8;
	localparam int GAIN_FRAC = 16;
	localparam longint VAL_MAX = 64'sd2147483647;
	localparam longint VAL_MIN = -64'sd2147483648;
	localparam logic signed [31:0] S_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] S_MIN = 32'sh8000_0000;
	localparam logic [30:0] LIM_MAX = 31'h7FFF_FFFF;
	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int LONG_HOLD = 300;
	localparam int PHASES = 12;
	localparam int PHASE_ITEMS = 110;
	localparam int REPORT_CAP = 100;

	// predicts the drive value of each sample beat and checks drive beats
	class drive_scoreboard;
		wepid_pkg::cfg_t cfg;
		longint error_sum;
		longint last_error;
		logic signed [31:0] expected_drive[$];
		int fail_count;

		function new();
			cfg = '0;
			error_sum = 0;
			last_error = 0;
			fail_count = 0;
		endfunction

		function longint sat_word(longint x);
			if (x > VAL_MAX) return VAL_MAX;
			if (x < VAL_MIN) return VAL_MIN;
			return x;
		endfunction

		function longint clip(longint x, longint lim);
			if (x < -lim) return -lim;
			if (x > lim) return lim;
			return x;
		endfunction

		// fold by a full turn once the error passes half a turn
		function longint fold_error(longint e, longint span);
			longint turn;
			longint mag;
			turn = span <<< FRAC;
			mag = (e < 0) ? -e : e;
			if (2 * mag > turn)
				e = (e >= 0) ? e - turn : e + turn;
			return e;
		endfunction

		// exact product, floor shift by the gain fraction, saturate
		function longint scale_gain(longint v, logic signed [31:0] g);
			logic signed [127:0] wide_v;
			logic signed [127:0] wide_g;
			logic signed [127:0] prod;
			wide_v = v;
			wide_g = g;
			prod = (wide_v * wide_g) >>> GAIN_FRAC;
			if (prod > VAL_MAX) return VAL_MAX;
			if (prod < VAL_MIN) return VAL_MIN;
			return longint'(prod);
		endfunction

		function void set_register(logic [3:0] idx, logic [31:0] data);
			case (idx)
				wepid_pkg::REG_GAIN_P: cfg.gain_p = data;
				wepid_pkg::REG_GAIN_I: cfg.gain_i = data;
				wepid_pkg::REG_GAIN_D: cfg.gain_d = data;
				wepid_pkg::REG_DEAD_BAND: cfg.dead_band = data[30:0];
				wepid_pkg::REG_INTEGRAL_LIMIT: cfg.integral_limit = data[30:0];
				wepid_pkg::REG_IOUT_LIMIT: cfg.iout_limit = data[30:0];
				wepid_pkg::REG_OUT_LIMIT: cfg.out_limit = data[30:0];
				wepid_pkg::REG_WRAP_MODE: cfg.wrap_mode = data[2:0];
				default: ;
			endcase
		endfunction

		function void take_sample(logic signed [31:0] tgt, logic signed [31:0] meas);
			longint t_l;
			longint m_l;
			longint err;
			longint mag;
			longint band;
			longint p_term;
			longint i_term;
			longint d_term;
			longint total;
			t_l = tgt;
			m_l = meas;
			band = cfg.dead_band;
			err = sat_word(t_l - m_l);
			case (cfg.wrap_mode)
				wepid_pkg::WRAP_8191:
					err = fold_error(err, wepid_pkg::FOLD_8191);
				wepid_pkg::WRAP_8191_4095:
					err = fold_error(fold_error(err, wepid_pkg::FOLD_8191),
						wepid_pkg::FOLD_4095);
				wepid_pkg::WRAP_360:
					err = fold_error(err, wepid_pkg::FOLD_360);
				wepid_pkg::WRAP_65535:
					err = fold_error(err, wepid_pkg::FOLD_65535);
				wepid_pkg::WRAP_65535_32767:
					err = fold_error(fold_error(err, wepid_pkg::FOLD_65535),
						wepid_pkg::FOLD_32767);
				default: ;
			endcase
			mag = (err < 0) ? -err : err;
			if (mag <= band)
				err = 0;
			error_sum = sat_word(clip(error_sum + err, cfg.integral_limit));
			p_term = scale_gain(err, cfg.gain_p);
			i_term = clip(scale_gain(error_sum, cfg.gain_i), cfg.iout_limit);
			d_term = scale_gain(err - last_error, cfg.gain_d);
			total = sat_word(clip(p_term + i_term + d_term, cfg.out_limit));
			last_error = err;
			expected_drive.push_back(total[31:0]);
		endfunction

		function void check_drive(logic signed [31:0] got);
			logic signed [31:0] want;
			if (expected_drive.size() == 0) begin
				fail_count++;
				if (fail_count <= REPORT_CAP)
					$error("drive: beat with nothing waiting, expected none, got %0d", got);
				return;
			end
			want = expected_drive.pop_front();
			if (got !== want) begin
				fail_count++;
				if (fail_count <= REPORT_CAP)
					$error("drive: expected %0d, got %0d", want, got);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic sample_valid;
	logic sample_stall;
	logic signed [31:0] target;
	logic signed [31:0] measure;
	logic drive_valid;
	logic drive_stall;
	logic signed [31:0] drive;
	logic cfg_valid;
	logic cfg_ready;
	logic [3:0] cfg_index;
	logic [31:0] cfg_data;

	bit steady;
	bit long_hold_req;
	int cycle_count = 0;
	int fold_spans[5] = '{wepid_pkg::FOLD_8191, wepid_pkg::FOLD_4095, wepid_pkg::FOLD_360,
		wepid_pkg::FOLD_65535, wepid_pkg::FOLD_32767};
	drive_scoreboard sb = new();

	wrapped_error_pid_controller_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.sample_valid(sample_valid),
		.sample_stall(sample_stall),
		.target(target),
		.measure(measure),
		.drive_valid(drive_valid),
		.drive_stall(drive_stall),
		.drive(drive),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// 100 MHz clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("wrapped_error_pid_controller_unit: mismatch");
			$finish;
		end
	end

	// beats on all three channels, seen with pre-edge values
	always @(posedge clk) begin
		if (arst_n === 1'b1) begin
			if (drive_valid && !drive_stall)
				sb.check_drive(drive);
			if (cfg_valid && cfg_ready)
				sb.set_register(cfg_index, cfg_data);
			if (sample_valid && !sample_stall)
				sb.take_sample(target, measure);
		end
	end

	// mostly short gaps, now and then a long one
	function automatic int unsigned pick_gap();
		int unsigned roll;
		if (steady) return 0;
		roll = $urandom_range(0, 99);
		if (roll < 55) return 0;
		if (roll < 88) return $urandom_range(1, 3);
		if (roll < 98) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [31:0] pick_gain();
		int unsigned roll;
		logic [31:0] mag;
		roll = $urandom_range(0, 9);
		mag = $urandom_range(0, 32'h0004_0000);
		case (roll)
			0: return S_MIN;
			1: return S_MAX;
			2: return '0;
			3, 4, 5, 6: return ($urandom_range(0, 1) != 0) ? -mag : mag;
			default: return $urandom();
		endcase
	endfunction

	function automatic logic [30:0] pick_limit();
		int unsigned roll;
		roll = $urandom_range(0, 9);
		case (roll)
			0: return '0;
			1, 2: return LIM_MAX;
			3, 4, 5, 6: return 31'($urandom_range(0, 32'h0010_0000));
			default: return 31'($urandom());
		endcase
	endfunction

	function automatic logic signed [31:0] pick_extreme();
		case ($urandom_range(0, 4))
			0: return S_MIN;
			1: return S_MAX;
			2: return 32'sd0;
			3: return -32'sd1;
			default: return 32'sd1;
		endcase
	endfunction

	// drive sink: random stalls, one long hold-off on request
	initial begin : drive_sink
		int unsigned span;
		drive_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (long_hold_req) begin
				drive_stall <= 1'b1;
				repeat (LONG_HOLD) @(posedge clk);
				drive_stall <= 1'b0;
				long_hold_req = 1'b0;
			end else begin
				span = pick_gap();
				if (span != 0) begin
					drive_stall <= 1'b1;
					repeat (span) @(posedge clk);
					drive_stall <= 1'b0;
				end
			end
		end
	end

	// one sample beat; valid stays up when no gap follows
	task automatic send_sample(logic signed [31:0] tgt, logic signed [31:0] meas);
		int unsigned gap;
		sample_valid <= 1'b1;
		target <= tgt;
		measure <= meas;
		do @(posedge clk); while (sample_stall);
		gap = pick_gap();
		if (gap != 0) begin
			sample_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic write_reg(logic [3:0] idx, logic [31:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// stop sending and wait for every expected drive beat
	task automatic drain_drive();
		sample_valid <= 1'b0;
		@(posedge clk);
		while (sb.expected_drive.size() != 0) @(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	// full register load; unused upper bits carry noise
	task automatic load_config(logic [31:0] gp, logic [31:0] gi, logic [31:0] gd,
			logic [30:0] band, logic [30:0] integ_lim, logic [30:0] iterm_lim,
			logic [30:0] out_lim, logic [2:0] mode);
		// an index past the register file must be dropped
		write_reg(4'(wepid_pkg::REG_WRAP_MODE) + 4'($urandom_range(1, 8)), $urandom());
		write_reg(wepid_pkg::REG_GAIN_P, gp);
		write_reg(wepid_pkg::REG_GAIN_I, gi);
		write_reg(wepid_pkg::REG_GAIN_D, gd);
		write_reg(wepid_pkg::REG_DEAD_BAND, {1'($urandom()), band});
		write_reg(wepid_pkg::REG_INTEGRAL_LIMIT, {1'($urandom()), integ_lim});
		write_reg(wepid_pkg::REG_IOUT_LIMIT, {1'($urandom()), iterm_lim});
		write_reg(wepid_pkg::REG_OUT_LIMIT, {1'($urandom()), out_lim});
		write_reg(wepid_pkg::REG_WRAP_MODE, {29'($urandom()), mode});
	endtask

	initial begin : stimulus
		logic signed [31:0] tgt;
		logic signed [31:0] meas;
		logic signed [31:0] delta;
		logic [30:0] band;
		int span;
		int unsigned roll;
		arst_n = 1'b0;
		sample_valid = 1'b0;
		target = '0;
		measure = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		steady = 1'b0;
		long_hold_req = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// saturating error and the dead band edge
		load_config(32'h0001_0000, 32'h0000_4000, 32'h0002_0000, 31'h100,
			LIM_MAX, LIM_MAX, LIM_MAX, wepid_pkg::WRAP_NONE);
		send_sample(32'sd0, 32'sd0);
		send_sample(S_MAX, S_MIN);
		send_sample(S_MIN, S_MAX);
		send_sample(S_MIN, 32'sd0);
		send_sample(32'sh100, 32'sd0);
		send_sample(32'sh101, 32'sd0);
		send_sample(32'sd0, 32'sh100);
		send_sample(32'sd0, 32'sh101);
		send_sample(S_MIN, S_MIN);
		drain_drive();

		// gain extremes against tight clamps
		load_config(S_MAX, S_MIN, S_MIN, 31'd0, 31'h3000, 31'h800, LIM_MAX,
			wepid_pkg::WRAP_NONE);
		send_sample(32'sd1, 32'sd0);
		send_sample(32'sd0, 32'sd1);
		send_sample(S_MAX, S_MIN);
		send_sample(S_MIN, S_MAX);
		send_sample(32'sd0, 32'sd0);
		drain_drive();

		// each fold just past half a turn, both signs; the unused mode too
		load_config(32'h0001_0000, 32'd0, 32'd0, 31'd0, LIM_MAX, LIM_MAX, LIM_MAX,
			wepid_pkg::WRAP_NONE);
		for (int w = wepid_pkg::WRAP_8191; w <= wepid_pkg::WRAP_65535_32767 + 1; w++) begin
			case (3'(w))
				wepid_pkg::WRAP_8191, wepid_pkg::WRAP_8191_4095:
					span = wepid_pkg::FOLD_8191;
				wepid_pkg::WRAP_65535, wepid_pkg::WRAP_65535_32767:
					span = wepid_pkg::FOLD_65535;
				default: span = wepid_pkg::FOLD_360;
			endcase
			write_reg(wepid_pkg::REG_WRAP_MODE, 32'(w));
			delta = 32'(span * 128 + 1);
			send_sample(delta, 32'sd0);
			send_sample(32'sd0, delta);
			drain_drive();
		end

		// random phases, each with its own register setting
		for (int ph = 0; ph < PHASES; ph++) begin
			steady = (ph == 2);
			case (ph)
				0: load_config(S_MAX, S_MAX, S_MAX, 31'd0, LIM_MAX, LIM_MAX, LIM_MAX,
					3'($urandom_range(0, 7)));
				1: load_config(S_MIN, S_MIN, S_MIN, LIM_MAX, 31'd0, 31'd0, 31'd0,
					3'($urandom_range(0, 7)));
				default: begin
					roll = $urandom_range(0, 9);
					if (roll < 4)
						band = '0;
					else if (roll < 8)
						band = 31'($urandom_range(0, 2048));
					else if (roll < 9)
						band = 31'($urandom_range(0, 32'h0040_0000));
					else
						band = 31'($urandom());
					load_config(pick_gain(), pick_gain(), pick_gain(), band, pick_limit(),
						pick_limit(), pick_limit(), 3'($urandom_range(0, 7)));
				end
			endcase
			// receiver holds off while samples keep coming
			if (ph == 3)
				long_hold_req = 1'b1;
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				if (k == PHASE_ITEMS / 2)
					drain_drive();
				roll = $urandom_range(0, 99);
				meas = $urandom();
				if (roll < 45) begin
					delta = $urandom_range(0, 8000);
					tgt = ($urandom_range(0, 1) != 0) ? meas + delta : meas - delta;
				end else if (roll < 70) begin
					// errors around half a turn of some fold
					delta = fold_spans[$urandom_range(0, 4)] * 128
						+ $urandom_range(0, 600) - 300;
					tgt = ($urandom_range(0, 1) != 0) ? meas + delta : meas - delta;
				end else if (roll < 88) begin
					tgt = $urandom();
				end else begin
					tgt = pick_extreme();
					meas = pick_extreme();
				end
				send_sample(tgt, meas);
			end
			drain_drive();
		end

		repeat (20) @(posedge clk);
		if (sb.fail_count == 0 && sb.expected_drive.size() == 0)
			$display("wrapped_error_pid_controller_unit: match");
		else
			$display("wrapped_error_pid_controller_unit: mismatch");
		$finish;
	end

endmodule
